/* hdl/json_string_unescape_utf8_assert.svh */
// Assertion macros for the JSON string unescaper.
// Included by the modules that check their own logic; no other dependencies.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

`ifndef SYNTH
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JSU_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define JSU_ASSERT(lbl, prop, msg)
`define JSU_NEVER(lbl, expr, msg)
`endif

`endif

/* hdl/jsu_pkg.sv */
// Types, constants and helper functions for the JSON string unescaper.
// No dependencies; imported by every module of the block.
package jsu_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = 3;
  localparam int unsigned HeldDepth  = 3;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;

  localparam logic [15:0] Utf8Lim1 = 16'h0080;
  localparam logic [15:0] Utf8Lim2 = 16'h0800;
  localparam logic [7:0]  Utf8Lead2 = 8'hC0;
  localparam logic [7:0]  Utf8Lead3 = 8'hE0;
  localparam logic [7:0]  Utf8Cont  = 8'h80;
  localparam logic [5:0]  Utf8Mask  = 6'h3F;

  typedef enum logic [5:0] {
    PH_NORMAL = 6'b000001,
    PH_ESC    = 6'b000010,
    PH_HEX0   = 6'b000100,
    PH_HEX1   = 6'b001000,
    PH_HEX2   = 6'b010000,
    PH_HEX3   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CntW-1:0]            cnt;
    logic                       term;
  } jsu_burst_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    case (c)
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

/* hdl/json_string_unescape_utf8.sv */
// JSON string unescaper with UTF-8 output. Each request carries one raw byte
// of a string body (after the opening quote); each result carries one decoded
// byte. A byte that decodes to k results (k up to 4: three flushed digits plus
// the offending byte, or a 3-byte UTF-8 sequence) holds the input until the
// single output register hands out the last byte of the burst; bytes yielding
// zero or one result flow at one per cycle while the output is not stalled.
// The first result appears in the cycle after its request is taken. tuser flags
// the end-of-string result (tdata is zero there), tlast marks the last result of each request.
// Depends on jsu_pkg, jsu_decode and jsu_serial.
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] end_flag
);

  jsu_burst_t burst;
  logic       take;
  logic       can_load;

  assign s_axis_tready = can_load;
  assign take          = s_axis_tvalid && can_load;

  jsu_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .byte_i  (s_axis_tdata),
    .burst_o (burst)
  );

  jsu_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .burst_i     (burst),
    .pop_ready_i (m_axis_tready),
    .can_load_o  (can_load),
    .valid_o     (m_axis_tvalid),
    .byte_o      (m_axis_tdata),
    .last_o      (m_axis_tlast),
    .term_o      (m_axis_tuser)
  );

endmodule

/* hdl/jsu_decode.sv */
// Escape decoder: phase, hex accumulator and held digit registers, plus the
// logic that turns one input byte into a burst of up to four bytes. Uses jsu_pkg.
`include "json_string_unescape_utf8_assert.svh"
module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  output jsu_burst_t burst_o
);

  phase_e      phase_q, phase_d;
  logic [11:0] accum_q, accum_d;
  logic [7:0]  held_q [HeldDepth];
  logic        held_we;
  logic [1:0]  taken;
  logic        in_hex;
  logic        plain;
  logic [4:0]  hex;
  logic        hex_ok;
  logic [3:0]  nib;
  logic [15:0] cp;
  jsu_burst_t  burst;

  always_comb begin
    hex    = hex_nib(byte_i);
    hex_ok = hex[4];
    nib    = hex[3:0];
    cp     = {accum_q, nib};
    taken  = 2'd0;
    in_hex = 1'b0;
    unique case (phase_q)
      PH_HEX0: begin in_hex = 1'b1; taken = 2'd0; end
      PH_HEX1: begin in_hex = 1'b1; taken = 2'd1; end
      PH_HEX2: begin in_hex = 1'b1; taken = 2'd2; end
      PH_HEX3: begin in_hex = 1'b1; taken = 2'd3; end
      default: begin in_hex = 1'b0; taken = 2'd0; end
    endcase
    plain = (!in_hex && phase_q != PH_ESC) || (in_hex && !hex_ok);

    burst   = '0;
    phase_d = phase_q;
    accum_d = accum_q;
    held_we = 1'b0;

    if (phase_q == PH_ESC) begin
      if (byte_i == ChU) begin
        phase_d = PH_HEX0;
        accum_d = '0;
      end else begin
        burst.bytes[0] = esc_map(byte_i);
        burst.cnt      = CntW'(1);
        phase_d        = PH_NORMAL;
      end
    end else if (plain) begin
      // flush digits of an aborted escape, then treat the byte as ordinary
      for (int i = 0; i < HeldDepth; i++) begin
        if (i < int'(taken)) burst.bytes[i] = held_q[i];
      end
      phase_d   = PH_NORMAL;
      burst.cnt = {1'b0, taken};
      if (byte_i == ChQuote) begin
        burst.bytes[taken] = 8'h00;
        burst.term         = 1'b1;
        burst.cnt          = {1'b0, taken} + CntW'(1);
      end else if (byte_i == ChBslash) begin
        phase_d = PH_ESC;
      end else begin
        burst.bytes[taken] = byte_i;
        burst.cnt          = {1'b0, taken} + CntW'(1);
      end
    end else if (taken != 2'd3) begin
      held_we = 1'b1;
      accum_d = {accum_q[7:0], nib};
      unique case (taken)
        2'd0:    phase_d = PH_HEX1;
        2'd1:    phase_d = PH_HEX2;
        default: phase_d = PH_HEX3;
      endcase
    end else begin
      if (cp < Utf8Lim1) begin
        burst.bytes[0] = cp[7:0];
        burst.cnt      = CntW'(1);
      end else if (cp < Utf8Lim2) begin
        burst.bytes[0] = Utf8Lead2 | {3'b000, cp[10:6]};
        burst.bytes[1] = Utf8Cont | {2'b00, cp[5:0] & Utf8Mask};
        burst.cnt      = CntW'(2);
      end else begin
        burst.bytes[0] = Utf8Lead3 | {4'h0, cp[15:12]};
        burst.bytes[1] = Utf8Cont | {2'b00, cp[11:6] & Utf8Mask};
        burst.bytes[2] = Utf8Cont | {2'b00, cp[5:0] & Utf8Mask};
        burst.cnt      = CntW'(3);
      end
      accum_d = '0;
      phase_d = PH_NORMAL;
    end
  end

  assign burst_o = burst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      accum_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      accum_q <= accum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && held_we) begin
      held_q[taken] <= byte_i;
    end
  end

  `JSU_ASSERT(a_esc_exit, take_i && phase_q == PH_ESC |=> phase_q == PH_NORMAL || phase_q == PH_HEX0, "escape phase left to a wrong phase")
  `JSU_ASSERT(a_digit_shift, take_i && held_we |=> accum_q[3:0] == $past(nib), "hex digit not shifted into accumulator")
  `JSU_NEVER(a_term_empty, burst.term && burst.cnt == '0, "end of string with no result")

endmodule

/* hdl/jsu_serial.sv */
// Output register: holds a decoded burst and hands it out one byte per request.
// Uses jsu_pkg.
`include "json_string_unescape_utf8_assert.svh"
module jsu_serial
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  jsu_burst_t burst_i,
  input  logic       pop_ready_i,
  output logic       can_load_o,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o,
  output logic       term_o
);

  logic [MaxResults-1:0][7:0] bytes_q, bytes_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       term_q, term_d;
  logic                       pop;

  assign pop        = (cnt_q != '0) && pop_ready_i;
  assign can_load_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && pop_ready_i);

  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    term_d  = term_q;
    if (load_i) begin
      bytes_d = burst_i.bytes;
      cnt_d   = burst_i.cnt;
      term_d  = burst_i.term;
    end else if (pop) begin
      // advance to the next byte
      bytes_d = {8'h00, bytes_q[MaxResults-1:1]};
      cnt_d   = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      term_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      term_q <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign valid_o = cnt_q != '0;
  assign byte_o  = bytes_q[0];
  assign last_o  = cnt_q == CntW'(1);
  assign term_o  = term_q && (cnt_q == CntW'(1));

  `JSU_NEVER(a_cnt_range, cnt_q > CntW'(MaxResults), "burst count out of range")
  `JSU_NEVER(a_load_busy, load_i && !can_load_o, "burst overwritten before drained")
  `JSU_ASSERT(a_drain, pop && cnt_q > CntW'(1) |=> cnt_q == $past(cnt_q) - CntW'(1), "burst count did not step down")

endmodule

/* test/tb.sv */
// Self-checking bench for the JSON string unescaper with UTF-8 output.
// Drives directed and random string bodies and checks every decoded result against a
// predictor (data is compared except on end-of-string results). Depends on jsu_pkg and json_string_unescape_utf8.
import jsu_pkg::*;

class unescape_scoreboard;
  typedef struct {
    logic [7:0] data;
    logic       term;
    logic       last;
  } decoded_t;

  phase_e     phase;
  logic [11:0] code_acc;
  logic [7:0]  digit_buf [3];
  decoded_t    decoded_q [$];
  int          n_errors;

  function new();
    phase    = PH_NORMAL;
    code_acc = '0;
    n_errors = 0;
  endfunction

  static function int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function void push(logic [7:0] data, logic term);
    decoded_t d;
    d.data = data;
    d.term = term;
    d.last = 1'b0;
    decoded_q.push_back(d);
  endfunction

  function void plain_byte(logic [7:0] b);
    phase = PH_NORMAL;
    if (b == ChQuote) begin
      push(8'h00, 1'b1);
    end else if (b == ChBslash) begin
      phase = PH_ESC;
    end else begin
      push(b, 1'b0);
    end
  endfunction

  function void emit_utf8(logic [15:0] cp);
    if (cp < Utf8Lim1) begin
      push(cp[7:0], 1'b0);
    end else if (cp < Utf8Lim2) begin
      push(Utf8Lead2 | {3'b000, cp[10:6]}, 1'b0);
      push(Utf8Cont | {2'b00, cp[5:0]}, 1'b0);
    end else begin
      push(Utf8Lead3 | {4'h0, cp[15:12]}, 1'b0);
      push(Utf8Cont | {2'b00, cp[11:6]}, 1'b0);
      push(Utf8Cont | {2'b00, cp[5:0]}, 1'b0);
    end
  endfunction

  function void note_request(logic [7:0] b);
    int         n_before;
    int         taken;
    int         nib;
    logic [7:0] c;
    n_before = decoded_q.size();
    case (phase)
      PH_ESC: begin
        phase = PH_NORMAL;
        if (b == ChU) begin
          phase    = PH_HEX0;
          code_acc = '0;
        end else begin
          case (b)
            "n":     c = 8'h0A;
            "r":     c = 8'h0D;
            "t":     c = 8'h09;
            "b":     c = 8'h08;
            "f":     c = 8'h0C;
            default: c = b;
          endcase
          push(c, 1'b0);
        end
      end
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        case (phase)
          PH_HEX0: taken = 0;
          PH_HEX1: taken = 1;
          PH_HEX2: taken = 2;
          default: taken = 3;
        endcase
        nib = nibble_of(b);
        if (nib < 0) begin
          for (int i = 0; i < taken; i++) push(digit_buf[i], 1'b0);
          plain_byte(b);
        end else if (taken < 3) begin
          digit_buf[taken] = b;
          code_acc = {code_acc[7:0], 4'(nib)};
          case (phase)
            PH_HEX0: phase = PH_HEX1;
            PH_HEX1: phase = PH_HEX2;
            default: phase = PH_HEX3;
          endcase
        end else begin
          emit_utf8({code_acc, 4'(nib)});
          code_acc = '0;
          phase    = PH_NORMAL;
        end
      end
      default: plain_byte(b);
    endcase
    if (decoded_q.size() > n_before) decoded_q[decoded_q.size() - 1].last = 1'b1;
  endfunction

  function void check_result(logic [7:0] data, logic term, logic last);
    decoded_t d;
    if (decoded_q.size() == 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("unexpected result: data %h end %b last %b", data, term, last);
      return;
    end
    d = decoded_q.pop_front();
    if (term !== d.term || last !== d.last || (!d.term && data !== d.data)) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch: expected data %h end %b last %b, got data %h end %b last %b",
                 d.data, d.term, d.last, data, term, last);
    end
  endfunction
endclass

module tb;
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  unescape_scoreboard sb = new();

  int   n_sent = 0;
  int   burst_left = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;
  int   stall_pct = 0;
  int   mode_left = 0;

  json_string_unescape_utf8 i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // hold off once for a long stretch, otherwise stall at a rate that changes by epoch
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_cnt++;
      if (hold_cnt == 300) hold_done = 1'b1;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  task automatic send_byte(input logic [7:0] b);
    int   gap;
    logic taken;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 30);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    sb.note_request(b);
    burst_left--;
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.decoded_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'("0") + 8'(n);
    return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = ChQuote;
      1:       c = ChBslash;
      default: begin
        do c = 8'($urandom); while (sb.nibble_of(c) >= 0);
      end
    endcase
    return c;
  endfunction

  task automatic send_unicode();
    logic [15:0] cp;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 7))
          0:       cp = 16'h0000;
          1:       cp = 16'h007F;
          2:       cp = 16'h0080;
          3:       cp = 16'h07FF;
          4:       cp = 16'h0800;
          5:       cp = 16'hD800;
          6:       cp = 16'hDFFF;
          default: cp = 16'hFFFF;
        endcase
      end
      1, 2:    cp = 16'($urandom_range(0, 16'h7F));
      3, 4:    cp = 16'($urandom_range(16'h80, 16'h7FF));
      5, 6, 7: cp = 16'($urandom_range(16'h800, 16'hFFFF));
      8:       cp = 16'($urandom_range(16'hD800, 16'hDFFF));
      default: cp = 16'($urandom);
    endcase
    send_byte(ChBslash);
    send_byte(ChU);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[i*4 +: 4]));
  endtask

  task automatic send_broken_unicode();
    int k;
    k = $urandom_range(0, 3);
    send_byte(ChBslash);
    send_byte(ChU);
    for (int i = 0; i < k; i++) send_byte(hex_char(4'($urandom)));
    send_byte(non_hex_byte());
  endtask

  task automatic send_simple_escape();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = ChQuote;
      1:       c = ChBslash;
      2:       c = "/";
      3:       c = "n";
      4:       c = "r";
      5:       c = "t";
      6:       c = "b";
      7:       c = "f";
      default: c = 8'($urandom);
    endcase
    send_byte(ChBslash);
    send_byte(c);
  endtask

  initial begin
    int  pick;
    int  n_directed;
    logic paused;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\\n\\\"\\uFFFF\\u0\"\\uaB1\\z\"");
    n_directed = n_sent;

    hold_go <= 1'b1;
    while (n_sent < n_directed + 400) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 38) begin
        send_byte(ChQuote);
      end else if (pick < 55) begin
        send_simple_escape();
      end else if (pick < 80) begin
        send_unicode();
      end else if (pick < 92) begin
        send_broken_unicode();
      end else begin
        send_byte(8'($urandom));
      end
      if (!paused && n_sent > n_directed + 200) begin
        paused = 1'b1;
        drain();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.decoded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
